[hdl/brf_pkg.sv]
// Shared types, constants and helpers for the byte ring FIFO.
package brf_pkg;

  localparam int DEPTH  = 1024;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = 10;
  localparam int BYTE_W = 8;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2,
    KIND_DROP = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data_in;
    cnt_t              position;
  } cmd_t;

  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] data_out;
    logic              overwrote;
    cnt_t              item_count;
  } result_t;

  // storage request from the pointer logic to the RAM
  typedef struct packed {
    logic              we;
    logic              re;
    ptr_t              addr;
    logic [BYTE_W-1:0] wdata;
  } ram_req_t;

  // registered status of the transaction in flight toward the result port
  typedef struct packed {
    logic valid;
    logic ok;
    logic use_data;
    logic overwrote;
    cnt_t item_count;
  } res_meta_t;

  // low CNT_W bits of a pointer-wide value, zero-extended if narrower
  function automatic cnt_t to_cnt(ptr_t v);
    logic [PTR_W+CNT_W-1:0] w;
    w = {{CNT_W{1'b0}}, v};
    return w[CNT_W-1:0];
  endfunction

endpackage

[hdl/brf_ram.sv]
// Generic single-port synchronous RAM with registered read.
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[hdl/brf_ctrl.sv]
// Pointer control: decodes the command, drives the RAM and updates pointers.
module brf_ctrl
  import brf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  cmd_t      cmd,
  output ram_req_t  req,
  output res_meta_t meta
);

  ptr_t wp, rp;
  ptr_t wp_next, rp_next;
  ptr_t count, count_after;
  logic full, empty, pos_in_range;
  logic [PTR_W+CNT_W-1:0] pos_ext, cnt_ext;
  ptr_t pos_ptr, drop_n;
  logic ok_c, use_c, ovw_c;

  assign count   = wp - rp;
  assign full    = (count == {PTR_W{1'b1}});
  assign empty   = (count == '0);
  assign pos_ext = {{PTR_W{1'b0}}, cmd.position};
  assign cnt_ext = {{CNT_W{1'b0}}, count};
  assign pos_in_range = (pos_ext < cnt_ext);
  assign pos_ptr = pos_ext[PTR_W-1:0];
  assign drop_n  = pos_in_range ? pos_ptr : count;

  always_comb begin
    wp_next   = wp;
    rp_next   = rp;
    req.we    = 1'b0;
    req.re    = 1'b0;
    req.addr  = rp;
    req.wdata = cmd.data_in;
    ok_c      = 1'b0;
    use_c     = 1'b0;
    ovw_c     = 1'b0;
    case (cmd.kind)
      KIND_PUSH: begin
        req.we   = accept;
        req.addr = wp;
        wp_next  = wp + 1'b1;
        ok_c     = 1'b1;
        if (full) begin
          rp_next = rp + 1'b1;
          ovw_c   = 1'b1;
        end
      end
      KIND_POP: begin
        if (!empty) begin
          req.re  = accept;
          rp_next = rp + 1'b1;
          ok_c    = 1'b1;
          use_c   = 1'b1;
        end
      end
      KIND_PEEK: begin
        if (pos_in_range) begin
          req.re   = accept;
          req.addr = rp + pos_ptr;
          ok_c     = 1'b1;
          use_c    = 1'b1;
        end
      end
      default: begin
        if (!empty) begin
          rp_next = rp + drop_n;
          ok_c    = 1'b1;
        end
      end
    endcase
  end

  assign count_after = wp_next - rp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      rp         <= '0;
      meta.valid <= 1'b0;
    end else begin
      meta.valid <= accept;
      if (accept) begin
        wp <= wp_next;
        rp <= rp_next;
      end
    end
    meta.ok         <= ok_c;
    meta.use_data   <= use_c;
    meta.overwrote  <= ovw_c;
    meta.item_count <= to_cnt(count_after);
  end

  // one storage access per transaction at most
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(req.we && req.re))
    else $error("RAM read and write in one cycle");

  // a result follows every accepted transaction and nothing else
  a_valid_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> meta.valid)
    else $error("accepted transaction gave no result");

  // an overwrite keeps the FIFO full
  a_ovw_full: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.kind == KIND_PUSH && full) |=>
      (meta.overwrote && meta.item_count == to_cnt({PTR_W{1'b1}})))
    else $error("overwrite did not keep FIFO full");

  // data is returned only on a successful read
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    meta.use_data |-> meta.ok)
    else $error("read data without success");

endmodule

[hdl/byte_ring_fifo_overwrite_peek.sv]
// Byte ring FIFO with overwrite-oldest, peek and multi-byte drop: top level.
// Result: the result strobe (done) comes from a register loaded at the accepting edge.
// Throughput: one transaction per cycle; busy stays low, each command makes
//   at most one access to the single-port byte RAM, whose registered read
//   delivers pop/peek data in the result cycle.
// Reset (rst, synchronous): both pointers cleared, FIFO empty, no result
//   pending; RAM contents are not cleared. The receiver cannot stall.
module byte_ring_fifo_overwrite_peek
  import brf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  ram_req_t          req;
  res_meta_t         meta;
  logic [BYTE_W-1:0] rdata;
  logic              accept;

  // every command needs at most one RAM access, so the block never holds off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // pointer logic: count, full/empty, clamping, RAM address selection
  brf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .req    (req),
    .meta   (meta)
  );

  // byte storage; a push writes at the accept edge, a pop or peek reads there
  // and the data shows up in the result cycle. A pop right after a push of the
  // same entry reads it at a later edge than the write, so no forwarding path is needed.
  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .re    (req.re),
    .addr  (req.addr),
    .wdata (req.wdata),
    .rdata (rdata)
  );

  // result assembly; data_out is zero unless a pop or peek succeeded
  assign done              = meta.valid;
  assign result.ok         = meta.ok;
  assign result.data_out   = meta.use_data ? rdata : '0;
  assign result.overwrote  = meta.overwrote;
  assign result.item_count = meta.item_count;

endmodule
